### rtl/core/sse_pkg.sv
// ----------------------------------------------------------------------------
// sse_pkg: shared types and constants for the sorted sparse entry table
// Opcodes, status codes, sequencer states and the cell broadcast bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package sse_pkg;

  localparam int ROW_W    = 10;
  localparam int COL_W    = 10;
  localparam int CFG_W    = 11;
  localparam int READ_W   = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 7;
  localparam int ADDR_W   = 3;
  localparam int PDATA_W  = 32;

  localparam logic [CFG_W-1:0] CFG_RESET = 11'd10;

  localparam logic OP_SET = 1'b0;
  localparam logic OP_GET = 1'b1;

  // register select is paddr[2]
  localparam logic REG_NUM_ROWS = 1'b0;
  localparam logic REG_NUM_COLS = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_UPDATED = 2'd1,
    ST_IGNORED = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_APPLY
  } state_t;

  // broadcast from the sequencer to every cell
  typedef struct packed {
    logic             cmp;
    logic             do_insert;
    logic             do_update;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
  } bcast_t;

endpackage

`default_nettype wire

### rtl/core/sse_ifs.sv
// ----------------------------------------------------------------------------
// sse_ifs: channel interfaces for the sorted sparse entry table
// Request and result channels with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface sse_in_if
  import sse_pkg::*;
#(
  parameter int VALUE_BITS = 32
) ();
  logic                         valid;
  logic                         ready;
  logic                         opcode;
  logic [ROW_W-1:0]             row;
  logic [COL_W-1:0]             col;
  logic signed [VALUE_BITS-1:0] value;

  modport source (output valid, opcode, row, col, value, input ready);
  modport sink   (input valid, opcode, row, col, value, output ready);
endinterface

interface sse_out_if
  import sse_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic signed [READ_W-1:0] read_value;
  logic [STATUS_W-1:0]      status;
  logic [COUNT_W-1:0]       stored_count;

  modport source (output valid, read_value, status, stored_count, input ready);
  modport sink   (input valid, read_value, status, stored_count, output ready);
endinterface

`default_nettype wire

### rtl/core/sse_cell.sv
// ----------------------------------------------------------------------------
// sse_cell: one slot of the sorted entry chain
// Compares its key with the broadcast key, then shifts, loads or updates.
// ----------------------------------------------------------------------------
`default_nettype none

module sse_cell
  import sse_pkg::*;
#(
  parameter int IDX        = 0,
  parameter int CNT_W      = 7,
  parameter int VALUE_BITS = 32
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire bcast_t           bcast,
  input  wire [CNT_W-1:0]       count,
  input  wire [VALUE_BITS-1:0]  new_value,
  input  wire                   prev_after,
  input  wire [ROW_W-1:0]       prev_row,
  input  wire [COL_W-1:0]       prev_col,
  input  wire [VALUE_BITS-1:0]  prev_value,
  output logic                  after_r,
  output logic                  hit_r,
  output logic [VALUE_BITS-1:0] hit_value_r,
  output logic [ROW_W-1:0]      row_r,
  output logic [COL_W-1:0]      col_r,
  output logic [VALUE_BITS-1:0] value_r
);

  logic occupied;
  logic key_ge;
  logic key_eq;

  assign occupied = CNT_W'(IDX) < count;
  assign key_eq   = (row_r == bcast.row) && (col_r == bcast.col);
  assign key_ge   = (row_r > bcast.row) || ((row_r == bcast.row) && (col_r >= bcast.col));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      after_r <= 1'b0;
      hit_r   <= 1'b0;
    end else if (bcast.cmp) begin
      after_r <= !occupied || key_ge;
      hit_r   <= occupied && key_eq;
    end
  end

  always_ff @(posedge clk) begin
    if (bcast.cmp) begin
      hit_value_r <= (occupied && key_eq) ? value_r : '0;
    end
  end

  // insert: slots past the insert point take their left neighbour
  always_ff @(posedge clk) begin
    if (bcast.do_insert && after_r) begin
      if (prev_after) begin
        row_r   <= prev_row;
        col_r   <= prev_col;
        value_r <= prev_value;
      end else begin
        row_r   <= bcast.row;
        col_r   <= bcast.col;
        value_r <= new_value;
      end
    end else if (bcast.do_update && hit_r) begin
      value_r <= new_value;
    end
  end

endmodule

`default_nettype wire

### rtl/core/sorted_sparse_entry_table.sv
// ----------------------------------------------------------------------------
// sorted_sparse_entry_table: sorted coordinate-list store for a sparse matrix
// Timing: a request beat enters CMP (cells compare), then APPLY (cells shift or
//   update, result register loaded); APPLY waits while the result is not taken.
// Requests: a new one is accepted only in IDLE or as APPLY retires; each
//   item passes the cell chain once in each phase, touching every cell.
// Reset: synchronous active-low; table empty, size registers 10 x 10.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_sparse_entry_table
  import sse_pkg::*;
#(
  parameter int MAX_ENTRIES = 64,
  parameter int INDEX_LIMIT = 1024,
  parameter int VALUE_BITS  = 32
) (
  input  wire                 clk,
  input  wire                 rst_n,
  sse_in_if.sink              in_ch,
  sse_out_if.source           out_ch,
  input  wire                 cfg_psel,
  input  wire                 cfg_penable,
  input  wire                 cfg_pwrite,
  input  wire [ADDR_W-1:0]    cfg_paddr,
  input  wire [PDATA_W-1:0]   cfg_pwdata,
  output logic [PDATA_W-1:0]  cfg_prdata,
  output logic                cfg_pready
);

  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

  // --------------------------------------------------------------------------
  // Configuration registers (APB, zero wait state)
  // --------------------------------------------------------------------------
  logic [CFG_W-1:0] num_rows_r;
  logic [CFG_W-1:0] num_cols_r;
  logic             cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_rows_r <= CFG_RESET;
      num_cols_r <= CFG_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[2])
        REG_NUM_ROWS: num_rows_r <= cfg_pwdata[CFG_W-1:0];
        REG_NUM_COLS: num_cols_r <= cfg_pwdata[CFG_W-1:0];
        default:      num_rows_r <= num_rows_r;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      REG_NUM_ROWS: cfg_prdata = PDATA_W'(num_rows_r);
      REG_NUM_COLS: cfg_prdata = PDATA_W'(num_cols_r);
      default:      cfg_prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer: IDLE -> CMP (cells compare) -> APPLY (cells shift/update,
  // result beat loaded). A new request is taken in the cycle that APPLY
  // retires, so back-to-back items skip IDLE.
  // --------------------------------------------------------------------------
  state_t state_r, state_nxt;

  logic                  op_r;
  logic [ROW_W-1:0]      row_r;
  logic [COL_W-1:0]      col_r;
  logic [VALUE_BITS-1:0] val_r;
  logic [CNT_W-1:0]      count_r, count_nxt;

  logic in_beat;
  logic apply_fire;
  logic out_free;

  assign out_free   = !out_ch.valid || out_ch.ready;
  assign apply_fire = (state_r == S_APPLY) && out_free;
  assign in_ch.ready = (state_r == S_IDLE) || apply_fire;
  assign in_beat    = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_beat) state_nxt = S_CMP;
      S_CMP:   state_nxt = S_APPLY;
      S_APPLY: begin
        if (apply_fire) state_nxt = in_beat ? S_CMP : S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // request holding register
  always_ff @(posedge clk) begin
    if (in_beat) begin
      op_r  <= in_ch.opcode;
      row_r <= in_ch.row;
      col_r <= in_ch.col;
      val_r <= VALUE_BITS'(in_ch.value);
    end
  end

  // --------------------------------------------------------------------------
  // Cell chain: slot i holds the i-th entry in (row, col) order; slots at or
  // past the entry count are empty. after flags form a suffix, so the first
  // set one is the insert point and the rest shift right by one.
  // --------------------------------------------------------------------------
  bcast_t                bcast;
  logic                  after_v   [MAX_ENTRIES];
  logic                  hit_v     [MAX_ENTRIES];
  logic [VALUE_BITS-1:0] hit_val_v [MAX_ENTRIES];
  logic [ROW_W-1:0]      crow_v    [MAX_ENTRIES];
  logic [COL_W-1:0]      ccol_v    [MAX_ENTRIES];
  logic [VALUE_BITS-1:0] cval_v    [MAX_ENTRIES];

  logic                  any_hit;
  logic [VALUE_BITS-1:0] hit_value;
  logic                  set_ok;
  logic                  tbl_full;
  logic                  do_insert;
  logic                  do_update;
  status_t               status;

  assign tbl_full = count_r == CNT_W'(MAX_ENTRIES);

  // set accepted only inside the configured size and index limit, and for a nonzero value
  assign set_ok = ({1'b0, row_r} < num_rows_r) && ({1'b0, col_r} < num_cols_r) &&
                  (32'(row_r) < INDEX_LIMIT) && (32'(col_r) < INDEX_LIMIT) &&
                  (val_r != '0);

  always_comb begin
    any_hit   = 1'b0;
    hit_value = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      any_hit   = any_hit | hit_v[i];
      hit_value = hit_value | hit_val_v[i];
    end
  end

  always_comb begin
    do_insert = 1'b0;
    do_update = 1'b0;
    priority if (op_r == OP_GET) begin
      status = any_hit ? ST_OK : ST_IGNORED;
    end else if (!set_ok) begin
      status = ST_IGNORED;
    end else if (any_hit) begin
      status    = ST_UPDATED;
      do_update = 1'b1;
    end else if (tbl_full) begin
      status = ST_FULL;
    end else begin
      status    = ST_OK;
      do_insert = 1'b1;
    end
  end

  assign count_nxt = (apply_fire && do_insert) ? count_r + CNT_W'(1) : count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  assign bcast.cmp       = (state_r == S_CMP);
  assign bcast.do_insert = apply_fire && do_insert;
  assign bcast.do_update = apply_fire && do_update;
  assign bcast.row       = row_r;
  assign bcast.col       = col_r;

  for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
    logic                  p_after;
    logic [ROW_W-1:0]      p_row;
    logic [COL_W-1:0]      p_col;
    logic [VALUE_BITS-1:0] p_val;

    if (g == 0) begin : g_head
      assign p_after = 1'b0;
      assign p_row   = '0;
      assign p_col   = '0;
      assign p_val   = '0;
    end else begin : g_link
      assign p_after = after_v[g-1];
      assign p_row   = crow_v[g-1];
      assign p_col   = ccol_v[g-1];
      assign p_val   = cval_v[g-1];
    end

    sse_cell #(
      .IDX        (g),
      .CNT_W      (CNT_W),
      .VALUE_BITS (VALUE_BITS)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .bcast       (bcast),
      .count       (count_r),
      .new_value   (val_r),
      .prev_after  (p_after),
      .prev_row    (p_row),
      .prev_col    (p_col),
      .prev_value  (p_val),
      .after_r     (after_v[g]),
      .hit_r       (hit_v[g]),
      .hit_value_r (hit_val_v[g]),
      .row_r       (crow_v[g]),
      .col_r       (ccol_v[g]),
      .value_r     (cval_v[g])
    );
  end

  // --------------------------------------------------------------------------
  // Result register: holds the beat until taken
  // --------------------------------------------------------------------------
  logic                     out_valid_r;
  logic signed [READ_W-1:0] read_value_r;
  logic [STATUS_W-1:0]      status_r;
  logic [COUNT_W-1:0]       stored_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (apply_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (apply_fire) begin
      read_value_r   <= (op_r == OP_GET && any_hit) ? READ_W'(hit_value) : '0;
      status_r       <= status;
      stored_count_r <= COUNT_W'(count_nxt);
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.read_value   = read_value_r;
  assign out_ch.status       = status_r;
  assign out_ch.stored_count = stored_count_r;

endmodule

`default_nettype wire
